/* sv/dd_odo_pkg.sv */
`default_nettype none
package dd_odo_pkg;

    localparam int CORDIC_TABLE_LEN = 24;
    localparam int STEP_W           = 5;
    localparam int ANG_W            = 34;
    localparam int DIV_BITS         = 41;
    localparam int DIV_CNT_W        = 6;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic signed [42:0] MAX32 = 43'sd2147483647;
    localparam logic signed [42:0] MIN32 = -43'sd2147483648;

    localparam logic [23:0] WHEEL_BASE_RESET = 24'd13107;

    typedef enum logic [1:0] {
        REG_TARGET_X   = 2'd0,
        REG_TARGET_Y   = 2'd1,
        REG_WHEEL_BASE = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            5'd0:  a = 34'sd210828714;
            5'd1:  a = 34'sd124459457;
            5'd2:  a = 34'sd65760959;
            5'd3:  a = 34'sd33381290;
            5'd4:  a = 34'sd16755422;
            5'd5:  a = 34'sd8385879;
            5'd6:  a = 34'sd4193963;
            5'd7:  a = 34'sd2097109;
            5'd8:  a = 34'sd1048571;
            5'd9:  a = 34'sd524287;
            5'd10: a = 34'sd262144;
            5'd11: a = 34'sd131072;
            5'd12: a = 34'sd65536;
            5'd13: a = 34'sd32768;
            5'd14: a = 34'sd16384;
            5'd15: a = 34'sd8192;
            5'd16: a = 34'sd4096;
            5'd17: a = 34'sd2048;
            5'd18: a = 34'sd1024;
            5'd19: a = 34'sd512;
            5'd20: a = 34'sd256;
            5'd21: a = 34'sd128;
            5'd22: a = 34'sd64;
            5'd23: a = 34'sd32;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'h7FFF_FFFF;
        end else if (v < MIN32) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/dd_odo_cordic.sv */
`default_nettype none
module dd_odo_cordic
    import dd_odo_pkg::*;
#(
    parameter int ITERS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire signed [15:0]  yaw,
    output logic               busy,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam logic [STEP_W-1:0] LAST = STEP_W'(ITERS - 1);

    logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    busy_reg;

    logic signed [ANG_W-1:0] z_in, z_wrap, z_next;
    logic                    neg_next;
    logic signed [ANG_W-1:0] x_sh, y_sh, x_neg, y_neg;

    always_comb begin
        z_in = {{2{yaw[15]}}, yaw, 16'b0};
        if (z_in > ANG_PI) begin
            z_wrap = z_in - ANG_TWO_PI;
        end else if (z_in < -ANG_PI) begin
            z_wrap = z_in + ANG_TWO_PI;
        end else begin
            z_wrap = z_in;
        end
        neg_next = 1'b1;
        if (z_wrap > ANG_HALF_PI) begin
            z_next = z_wrap - ANG_PI;
        end else if (z_wrap < -ANG_HALF_PI) begin
            z_next = z_wrap + ANG_PI;
        end else begin
            z_next   = z_wrap;
            neg_next = 1'b0;
        end
        x_sh  = x_reg >>> step_reg;
        y_sh  = y_reg >>> step_reg;
        x_neg = -x_reg;
        y_neg = -y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_next;
            neg_reg  <= neg_next;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_q28(step_reg);
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_q28(step_reg);
            end
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_out = neg_reg ? x_neg[31:0] : x_reg[31:0];
    assign sin_out = neg_reg ? y_neg[31:0] : y_reg[31:0];

endmodule
`default_nettype wire

/* sv/dd_odo_div.sv */
`default_nettype none
module dd_odo_div
    import dd_odo_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire signed [24:0]  diff,
    input  wire [23:0]         divisor,
    output logic               busy,
    output logic signed [41:0] quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_BITS - 1);

    logic [DIV_BITS-1:0]  num_reg, quot_reg;
    logic [23:0]          rem_reg, den_reg;
    logic                 neg_reg, zero_reg, busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [24:0]          mag;
    logic [24:0]          trial;
    logic                 fits;
    logic [24:0]          trial_sub;
    logic signed [41:0]   q_pos;

    always_comb begin
        mag       = diff[24] ? 25'(-diff) : 25'(diff);
        trial     = {rem_reg, num_reg[DIV_BITS-1]};
        fits      = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
        q_pos     = {1'b0, quot_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            num_reg  <= {mag, 16'b0};
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= divisor;
            neg_reg  <= diff[24];
            zero_reg <= (divisor == '0);
        end else if (busy_reg) begin
            num_reg  <= {num_reg[DIV_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_BITS-2:0], fits};
            rem_reg  <= fits ? trial_sub[23:0] : trial[23:0];
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? -q_pos : q_pos);

endmodule
`default_nettype wire

/* sv/differential_drive_odometry.sv */
// Each accepted request runs the 41-step bit-serial divider alongside the CORDIC
// (min(CORDIC_STEPS, 24) steps), then S_MULX, S_MULY, S_ACC, S_OFS and S_PUSH, which
// waits while an earlier result is not taken. A new request is taken once the result is
// loaded into the output register, even while that result still waits.
// Reset: synchronous, active low; clears position, heading, distance, stored yaw and
// targets, and sets the wheel base to 13107.
`default_nettype none
module differential_drive_odometry
    import dd_odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,    // left_travel, right_travel, yaw_angle
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [191:0] m_tdata,    // pos_x, pos_y, offset_x, offset_y, wheel_heading,
                                     // distance_sum
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);

    localparam int CORDIC_ITERS =
        (CORDIC_STEPS < CORDIC_TABLE_LEN) ? CORDIC_STEPS : CORDIC_TABLE_LEN;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_MULX, S_MULY, S_ACC, S_OFS, S_PUSH
    } state_t;

    state_t state_reg;

    logic signed [31:0]  target_x_reg, target_y_reg;
    logic [23:0]         wheel_base_reg;
    logic signed [31:0]  x_acc_reg, y_acc_reg, heading_acc_reg, travel_acc_reg;
    logic signed [15:0]  prior_yaw_reg;
    logic signed [23:0]  centre_reg;
    logic signed [55:0]  prod_reg;
    logic signed [25:0]  dx_reg;
    logic signed [41:0]  dth_reg;
    logic signed [31:0]  offset_x_reg, offset_y_reg;
    logic                m_tvalid_reg;
    logic [191:0]        m_tdata_reg;

    logic                accept;
    logic signed [23:0]  s_left, s_right;
    logic signed [15:0]  s_yaw;
    logic signed [24:0]  sum_lr, diff_lr;
    logic                cordic_busy, div_busy;
    logic signed [31:0]  cos_w, sin_w;
    logic signed [41:0]  quot_w;
    logic signed [55:0]  prod_next;
    logic signed [55:0]  rnd;
    logic signed [25:0]  dy_w;
    logic signed [42:0]  x_sum, y_sum, h_sum, t_sum, ox_dif, oy_dif;

    assign s_left   = s_tdata[23:0];
    assign s_right  = s_tdata[47:24];
    assign s_yaw    = s_tdata[63:48];
    assign sum_lr   = 25'(s_left) + 25'(s_right);
    assign diff_lr  = 25'(s_right) - 25'(s_left);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    dd_odo_cordic #(
        .ITERS (CORDIC_ITERS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .yaw     (prior_yaw_reg),
        .busy    (cordic_busy),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    dd_odo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .diff     (diff_lr),
        .divisor  (wheel_base_reg),
        .busy     (div_busy),
        .quotient (quot_w)
    );

    always_comb begin
        prod_next = centre_reg * ((state_reg == S_MULX) ? cos_w : sin_w);
        rnd       = prod_reg + 56'sd536870912;
        dy_w      = rnd[55:30];
        x_sum     = 43'(x_acc_reg) + 43'(dx_reg);
        y_sum     = 43'(y_acc_reg) + 43'(dy_w);
        h_sum     = 43'(heading_acc_reg) + 43'(dth_reg);
        t_sum     = 43'(travel_acc_reg) + 43'(centre_reg);
        ox_dif    = 43'(target_x_reg) - 43'(x_acc_reg);
        oy_dif    = 43'(target_y_reg) - 43'(y_acc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            wheel_base_reg  <= WHEEL_BASE_RESET;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            heading_acc_reg <= '0;
            travel_acc_reg  <= '0;
            prior_yaw_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TARGET_X:   target_x_reg   <= cfg_data;
                    REG_TARGET_Y:   target_y_reg   <= cfg_data;
                    REG_WHEEL_BASE: wheel_base_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_PUSH) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        centre_reg    <= sum_lr[24:1];
                        prior_yaw_reg <= s_yaw;
                        state_reg     <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!cordic_busy && !div_busy) begin
                        dth_reg   <= quot_w;
                        state_reg <= S_MULX;
                    end
                end
                S_MULX: begin
                    prod_reg  <= prod_next;
                    state_reg <= S_MULY;
                end
                S_MULY: begin
                    dx_reg    <= rnd[55:30];
                    prod_reg  <= prod_next;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    x_acc_reg       <= sat32(x_sum);
                    y_acc_reg       <= sat32(y_sum);
                    heading_acc_reg <= sat32(h_sum);
                    travel_acc_reg  <= sat32(t_sum);
                    state_reg       <= S_OFS;
                end
                S_OFS: begin
                    offset_x_reg <= sat32(ox_dif);
                    offset_y_reg <= sat32(oy_dif);
                    state_reg    <= S_PUSH;
                end
                S_PUSH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {travel_acc_reg, heading_acc_reg, offset_y_reg,
                                         offset_x_reg, y_acc_reg, x_acc_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!cordic_busy && !div_busy))
        else $error("arithmetic unit busy while idle");

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RUN && cordic_busy && div_busy))
        else $error("request did not start both units");

    a_zero_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC && dth_reg == '0) |=> $stable(heading_acc_reg))
        else $error("heading moved with zero increment");

    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result not presented");
`endif

endmodule
`default_nettype wire
